// File: rtl/fop_pkg.sv
// Package for the FP4 outer-product MAC tile: beat types, function codes,
// tile size defaults and the FP4 code decode. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fop_pkg;

   // Default tile size
   localparam int TILE_ROWS_DEF = 8;
   localparam int TILE_COLS_DEF = 8;

   // Codes packed in one 32-bit word, and accumulator width
   localparam int CODES_PER_WORD = 8;
   localparam int ACC_W          = 16;

   // Function selector codes
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_MAC   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Input beat
   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] weight_codes;
      logic [31:0] act_codes;
   } fop_req_type;

   // Result beat
   typedef struct packed {
      logic [2:0]               row;
      logic [2:0]               col;
      logic signed [ACC_W-1:0]  value;
      logic                     last;
   } fop_rsp_type;

   // Per-cell control, shared by every cell of the tile
   typedef struct packed {
      logic clr;
      logic mac;
      logic shift;
   } fop_cell_ctl_type;

   // Drain controller status toward the top level
   typedef struct packed {
      logic busy;
      logic shift;
      logic last_shift;
   } fop_drain_stat_type;

   // FP4 E2M1 code to integer at twice the E2M1 value; negative zero maps to 0
   function automatic logic signed [4:0] fp4_decode(input logic [3:0] code);
      logic signed [4:0] v;
      case (code)
         4'h0:    v = 5'sd0;
         4'h1:    v = 5'sd1;
         4'h2:    v = 5'sd2;
         4'h3:    v = 5'sd3;
         4'h4:    v = 5'sd4;
         4'h5:    v = 5'sd6;
         4'h6:    v = 5'sd8;
         4'h7:    v = 5'sd12;
         4'h8:    v = 5'sd0;
         4'h9:    v = -5'sd1;
         4'hA:    v = -5'sd2;
         4'hB:    v = -5'sd3;
         4'hC:    v = -5'sd4;
         4'hD:    v = -5'sd6;
         4'hE:    v = -5'sd8;
         default: v = -5'sd12;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/fp4_outer_product_mac_tile.sv
// Top level of the FP4 outer-product MAC tile: request decode, the cell
// array with its readback shift chain, and the drain controller.
// Depends on fop_pkg, fop_cell and fop_drain.
`timescale 1ns / 1ps
`default_nettype none

// A TILE_ROWS x TILE_COLS tile of 16-bit wrapping accumulators, one cell per
// entry, all working in parallel. Clear and mac beats may follow one another
// back to back. A readback beat drains the tile through a shift chain in
// row-major order, one entry per cycle into the result register while that
// register is free or being emptied; req_ready stays low during the drain.
// The chain shifts in zeros, so the tile is clear once the final entry
// (marked by last) has left. Rows or columns past the eighth see code 0.
// Function code 3 is accepted and ignored.
module fp4_outer_product_mac_tile #(
   parameter int TILE_ROWS = fop_pkg::TILE_ROWS_DEF,
   parameter int TILE_COLS = fop_pkg::TILE_COLS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire fop_pkg::fop_req_type  req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      fop_pkg::fop_rsp_type  rsp_data
);

   localparam int NCELL = TILE_ROWS * TILE_COLS;

   logic                          req_take;
   fop_pkg::fop_cell_ctl_type     cell_ctl;
   fop_pkg::fop_drain_stat_type   drain_stat;
   logic [fop_pkg::ACC_W-1:0]     acc [NCELL];
   logic [NCELL-1:0]              acc_nz;

   // Request side: held off while a readback drains
   assign req_ready    = !drain_stat.busy;
   assign req_take     = req_valid && req_ready;
   assign cell_ctl.clr   = req_take && (req_data.func == fop_pkg::FUNC_CLEAR);
   assign cell_ctl.mac   = req_take && (req_data.func == fop_pkg::FUNC_MAC);
   assign cell_ctl.shift = drain_stat.shift;

   // Cell array; entry k shifts from entry k+1, the tail takes zero
   for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
      for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
         logic [3:0]                w_code;
         logic [3:0]                a_code;
         logic [fop_pkg::ACC_W-1:0] shift_in;

         if (r < fop_pkg::CODES_PER_WORD) begin : g_w
            assign w_code = req_data.weight_codes[4*r +: 4];
         end else begin : g_wz
            assign w_code = 4'h0;
         end

         if (c < fop_pkg::CODES_PER_WORD) begin : g_a
            assign a_code = req_data.act_codes[4*c +: 4];
         end else begin : g_az
            assign a_code = 4'h0;
         end

         if (r * TILE_COLS + c == NCELL - 1) begin : g_tail
            assign shift_in = '0;
         end else begin : g_link
            assign shift_in = acc[r*TILE_COLS + c + 1];
         end

         fop_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .w_code   (w_code),
            .a_code   (a_code),
            .shift_in (shift_in),
            .acc      (acc[r*TILE_COLS + c])
         );

         assign acc_nz[r*TILE_COLS + c] = |acc[r*TILE_COLS + c];
      end
   end

   // Readback drain and result register
   fop_drain #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) u_drain (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take && (req_data.func == fop_pkg::FUNC_READ)),
      .head      (acc[0]),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (drain_stat)
   );

   // Checks
   a_readback_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.func == fop_pkg::FUNC_READ)) |=> drain_stat.busy)
      else $error("readback beat did not start a drain");

   a_no_shift_with_req: assert property (@(posedge clock) disable iff (reset)
      drain_stat.shift |-> !req_take)
      else $error("request accepted while the tile shifts");

   a_tile_clear_after_drain: assert property (@(posedge clock) disable iff (reset)
      drain_stat.last_shift |=> (acc_nz == '0))
      else $error("tile not clear after final readback entry");

   a_last_flag_on_final: assert property (@(posedge clock) disable iff (reset)
      drain_stat.last_shift |=> (rsp_valid && rsp_data.last && !drain_stat.busy))
      else $error("final entry not flagged or drain still busy");

endmodule

`default_nettype wire

// File: rtl/fop_cell.sv
// One accumulator cell of the tile: FP4 decode, small multiply, wrapping add,
// clear and shift-chain move for readback. Depends on fop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fop_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fop_pkg::fop_cell_ctl_type       ctl,
   input  wire logic [3:0]                      w_code,
   input  wire logic [3:0]                      a_code,
   input  wire logic [fop_pkg::ACC_W-1:0]       shift_in,
   output      logic [fop_pkg::ACC_W-1:0]       acc
);

   logic signed [4:0]              w_val;
   logic signed [4:0]              a_val;
   logic signed [9:0]              prod;
   logic [fop_pkg::ACC_W-1:0]      acc_ff;
   logic [fop_pkg::ACC_W-1:0]      acc_in;

   // Decode and multiply; product fits 10 bits signed (|p| <= 144)
   assign w_val = fop_pkg::fp4_decode(w_code);
   assign a_val = fop_pkg::fp4_decode(a_code);
   assign prod  = w_val * a_val;

   // Next accumulator value
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clr) begin
         acc_in = '0;
      end else if (ctl.shift) begin
         acc_in = shift_in;
      end else if (ctl.mac) begin
         acc_in = acc_ff + {{(fop_pkg::ACC_W-10){prod[9]}}, prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// File: rtl/fop_drain.sv
// Readback drain: row/column counters, shift-chain pacing and the result
// output register. Depends on fop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fop_drain #(
   parameter int TILE_ROWS = fop_pkg::TILE_ROWS_DEF,
   parameter int TILE_COLS = fop_pkg::TILE_COLS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [fop_pkg::ACC_W-1:0]     head,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_valid,
   output      fop_pkg::fop_rsp_type          rsp_data,
   output      fop_pkg::fop_drain_stat_type   stat
);

   localparam int RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fop_pkg::fop_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   shift;
   logic                   row_max;
   logic                   col_max;
   logic                   last_entry;
   logic [RW+2:0]          row_ext;
   logic [CW+2:0]          col_ext;

   assign row_max    = (row_ff == RW'(TILE_ROWS - 1));
   assign col_max    = (col_ff == CW'(TILE_COLS - 1));
   assign last_entry = row_max && col_max;
   assign row_ext    = {3'b000, row_ff};
   assign col_ext    = {3'b000, col_ff};

   // Move one entry when the output register is free or being emptied
   assign shift = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);

   // State and counters
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (shift) begin
               if (last_entry) begin
                  state_in = ST_IDLE;
                  row_in   = '0;
                  col_in   = '0;
               end else if (col_max) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (shift) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in.row   = row_ext[2:0];
         rsp_data_in.col   = col_ext[2:0];
         rsp_data_in.value = head;
         rsp_data_in.last  = last_entry;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign stat.busy       = (state_ff == ST_DRAIN);
   assign stat.shift      = shift;
   assign stat.last_shift = shift && last_entry;

endmodule

`default_nettype wire
